// ----- src/frp_pkg.sv -----
package frp_pkg;

   localparam int NOW_W             = 32;
   localparam int FPS_W             = 10;
   localparam int FC_W              = 32;
   localparam int OVR_W             = 7;
   localparam int WAIT_W            = 10;
   localparam int RSP_W             = 16;
   localparam int CAP_BITS          = 42;
   localparam int TIME_BITS_DEFAULT = 32;

   localparam int MS_PER_S = 1000;
   // One second in milliseconds is 2^10 - 2^4 - 2^3.
   localparam int MS_SH_A  = 10;
   localparam int MS_SH_B  = 4;
   localparam int MS_SH_C  = 3;

   localparam logic [OVR_W-1:0] OVERRUN_LIMIT = OVR_W'(120);
   localparam logic [FPS_W-1:0] FPS_DEFAULT   = FPS_W'(60);

   localparam logic KIND_RESTART = 1'b0;
   localparam logic KIND_FRAME   = 1'b1;

   typedef struct packed {
      logic              done;
      logic              ahead;
      logic [WAIT_W-1:0] wait_ms;
   } frp_res_type;

endpackage

// ----- src/frame_rate_pacer.sv -----
// Restart item: clears the pacing state and goes straight to the result hand-off.
// Frame-end item: a start step, a shift-add multiply over the fps bits, a compare step, a restoring
// divide and the hand-off steps; a late frame or a saturated wait skips the divide, and an elapsed
// time wider than CAP_BITS skips the multiply too. Items are taken one at a time; the next item can
// be accepted in the same cycle as the result becomes valid; a result held by the receiver stalls
// the input. Reset clears state and loads fps_target with 60.
module frame_rate_pacer import frp_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [FPS_W-1:0]  csr_data,   // fps_target
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [NOW_W-1:0]  req_tdata,  // now_ms
   input  logic              req_tuser,  // kind
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata   // wait_ms, time_over, restarted, zero fill
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CALC = 2'd1;
   localparam logic [1:0] S_FIN  = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [FPS_W-1:0]     fps_ff, fps_in;
   logic [TIME_BITS-1:0] begin_ff, begin_in;
   logic [FC_W-1:0]      fc_ff, fc_in;
   logic [OVR_W-1:0]     oc_ff, oc_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [WAIT_W-1:0]    pw_ff, pw_in;
   logic                 po_ff, po_in;
   logic                 pr_ff, pr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WAIT_W-1:0]    rsp_wait_ff, rsp_wait_in;
   logic                 rsp_over_ff, rsp_over_in;
   logic                 rsp_rst_ff, rsp_rst_in;

   logic                 accept;
   logic                 load;
   logic                 start;
   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] elapsed;
   logic [FC_W-1:0]      fc_inc;
   logic [FPS_W-1:0]     fps_eff;
   logic [OVR_W-1:0]     oc_nx;
   frp_res_type          res;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign now_t      = TIME_BITS'(req_tdata);
   assign elapsed    = now_t - begin_ff;
   assign fc_inc     = fc_ff + FC_W'(1);
   assign fps_eff    = (fps_ff == '0) ? FPS_W'(1) : fps_ff;
   assign oc_nx      = oc_ff + OVR_W'(1);
   assign start      = accept && (req_tuser == KIND_FRAME);
   assign load       = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_tready);

   frp_engine #(
      .TIME_BITS(TIME_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .elapsed     (elapsed),
      .frame_count (fc_inc),
      .fps         (fps_eff),
      .res         (res)
   );

   always_comb begin
      state_in = state_ff;
      fps_in   = csr_valid ? csr_data : fps_ff;
      begin_in = begin_ff;
      fc_in    = fc_ff;
      oc_in    = oc_ff;
      now_in   = now_ff;
      pw_in    = pw_ff;
      po_in    = po_ff;
      pr_in    = pr_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               now_in = now_t;
               if (req_tuser == KIND_RESTART) begin
                  begin_in = now_t;
                  fc_in    = '0;
                  oc_in    = '0;
                  pw_in    = '0;
                  po_in    = 1'b0;
                  pr_in    = 1'b1;
                  state_in = S_FIN;
               end else begin
                  fc_in    = fc_inc;
                  state_in = S_CALC;
               end
            end
         end
         S_CALC: begin
            if (res.done) begin
               state_in = S_FIN;
               if (res.ahead) begin
                  oc_in = '0;
                  pw_in = res.wait_ms;
                  po_in = 1'b0;
                  pr_in = 1'b0;
               end else begin
                  pw_in = '0;
                  po_in = 1'b1;
                  if (oc_nx > OVERRUN_LIMIT) begin
                     begin_in = now_ff;
                     fc_in    = '0;
                     oc_in    = '0;
                     pr_in    = 1'b1;
                  end else begin
                     oc_in = oc_nx;
                     pr_in = 1'b0;
                  end
               end
            end
         end
         S_FIN: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_wait_in  = rsp_wait_ff;
      rsp_over_in  = rsp_over_ff;
      rsp_rst_in   = rsp_rst_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_wait_in  = pw_ff;
         rsp_over_in  = po_ff;
         rsp_rst_in   = pr_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fps_ff       <= FPS_DEFAULT;
         begin_ff     <= '0;
         fc_ff        <= '0;
         oc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fps_ff       <= fps_in;
         begin_ff     <= begin_in;
         fc_ff        <= fc_in;
         oc_ff        <= oc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff      <= now_in;
      pw_ff       <= pw_in;
      po_ff       <= po_in;
      pr_ff       <= pr_in;
      rsp_wait_ff <= rsp_wait_in;
      rsp_over_ff <= rsp_over_in;
      rsp_rst_ff  <= rsp_rst_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W - WAIT_W - 2){1'b0}}, rsp_rst_ff, rsp_over_ff, rsp_wait_ff};

   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      res.done |-> state_ff == S_CALC)
      else $error("engine result outside of calculation");

   a_overrun_bound: assert property (@(posedge clock) disable iff (reset)
      oc_ff <= OVERRUN_LIMIT)
      else $error("overrun count above limit");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      accept && (req_tuser == KIND_RESTART)
      |=> fc_ff == '0 && oc_ff == '0 && begin_ff == $past(now_t))
      else $error("restart item did not clear pacing state");

   a_over_no_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_over_ff |-> rsp_wait_ff == '0)
      else $error("late result carries a wait");

endmodule

// ----- src/frp_engine.sv -----
module frp_engine import frp_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TIME_BITS-1:0] elapsed,
   input  logic [FC_W-1:0]      frame_count,
   input  logic [FPS_W-1:0]     fps,
   output frp_res_type          res
);

   localparam int EW    = (TIME_BITS < CAP_BITS) ? TIME_BITS : CAP_BITS;
   localparam int PW    = EW + FPS_W;
   localparam int NW    = FC_W + FPS_W;
   localparam int W     = (PW > NW) ? PW : NW;
   localparam int CNT_W = $clog2(FPS_W);

   localparam logic [1:0] E_IDLE = 2'd0;
   localparam logic [1:0] E_MUL  = 2'd1;
   localparam logic [1:0] E_CMP  = 2'd2;
   localparam logic [1:0] E_DIV  = 2'd3;

   logic [1:0]        st_ff, st_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [FPS_W-1:0]  mplr_ff, mplr_in;
   logic [EW-1:0]     mcand_ff, mcand_in;
   logic [W-1:0]      acc_ff, acc_in;
   logic [W-1:0]      n_ff, n_in;
   logic [W-1:0]      div_ff, div_in;
   logic [FPS_W-1:0]  q_ff, q_in;
   logic              done_ff, done_in;
   logic              ahead_ff, ahead_in;
   logic [WAIT_W-1:0] wait_ff, wait_in;
   logic              cap;
   logic              fit;
   logic [W-1:0]      rem;
   logic [W-1:0]      fc_w;

   assign cap  = (TIME_BITS > CAP_BITS) && ((elapsed >> CAP_BITS) != '0);
   assign fc_w = W'(frame_count);
   assign rem  = n_ff - acc_ff;
   assign fit  = (acc_ff >= div_ff);

   always_comb begin
      st_in    = st_ff;
      cnt_in   = cnt_ff;
      mplr_in  = mplr_ff;
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      n_in     = n_ff;
      div_in   = div_ff;
      q_in     = q_ff;
      done_in  = 1'b0;
      ahead_in = ahead_ff;
      wait_in  = wait_ff;
      case (st_ff)
         E_IDLE: begin
            if (start) begin
               if (cap) begin
                  done_in  = 1'b1;
                  ahead_in = 1'b0;
                  wait_in  = '0;
               end else begin
                  mplr_in  = fps;
                  mcand_in = elapsed[EW-1:0];
                  acc_in   = '0;
                  n_in     = (fc_w << MS_SH_A) - (fc_w << MS_SH_B) - (fc_w << MS_SH_C);
                  cnt_in   = CNT_W'(FPS_W - 1);
                  st_in    = E_MUL;
               end
            end
         end
         E_MUL: begin
            acc_in  = (acc_ff << 1) + (mplr_ff[FPS_W-1] ? W'(mcand_ff) : W'(0));
            mplr_in = {mplr_ff[FPS_W-2:0], mplr_ff[FPS_W-1]};
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               st_in = E_CMP;
            end
         end
         E_CMP: begin
            if (acc_ff >= n_ff) begin
               done_in  = 1'b1;
               ahead_in = 1'b0;
               wait_in  = '0;
               st_in    = E_IDLE;
            end else if (rem >= (W'(mplr_ff) << FPS_W)) begin
               done_in  = 1'b1;
               ahead_in = 1'b1;
               wait_in  = '1;
               st_in    = E_IDLE;
            end else begin
               acc_in = rem;
               div_in = W'(mplr_ff) << (FPS_W - 1);
               q_in   = '0;
               cnt_in = CNT_W'(FPS_W - 1);
               st_in  = E_DIV;
            end
         end
         E_DIV: begin
            if (fit) begin
               acc_in = acc_ff - div_ff;
            end
            q_in   = {q_ff[FPS_W-2:0], fit};
            div_in = div_ff >> 1;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               ahead_in = 1'b1;
               wait_in  = WAIT_W'(q_in);
               st_in    = E_IDLE;
            end
         end
         default: begin
            st_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= E_IDLE;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      mplr_ff  <= mplr_in;
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
      n_ff     <= n_in;
      div_ff   <= div_in;
      q_ff     <= q_in;
      ahead_ff <= ahead_in;
      wait_ff  <= wait_in;
   end

   assign res.done    = done_ff;
   assign res.ahead   = ahead_ff;
   assign res.wait_ms = wait_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> st_ff == E_IDLE)
      else $error("engine started while busy");

   a_late_no_wait: assert property (@(posedge clock) disable iff (reset)
      done_ff && !ahead_ff |-> wait_ff == '0)
      else $error("late frame reports a wait");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("engine done held for more than one cycle");

endmodule
